// ----- hw/rtl/bscs_pkg.sv -----
`timescale 1ns / 1ps

package bscs_pkg;

  // Fixed field widths.
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 48;
  localparam int POS_W  = 17;
  localparam int VIDX_W = 10;
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_ADDR_W  = 3;

  // Request kinds carried in in_tuser.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ELEM = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_RE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_IM = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BETA_RE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BETA_IM  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLK_SIZE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_BROW = 3'd5;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat32_t;

  // Clip a wide value to the 32-bit signed range and report clipping.
  function automatic sat32_t sat32(input logic signed [49:0] v);
    sat32_t res;
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) begin
      res.sat = 1'b1;
      res.val = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      res.sat = 1'b1;
      res.val = 32'sh8000_0000;
    end else begin
      res.sat = 1'b0;
      res.val = v[DATA_W-1:0];
    end
    return res;
  endfunction

  // Clip a wide value to the 48-bit signed accumulator range.
  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = (50'sd1 <<< 47) - 50'sd1;
    lo = -(50'sd1 <<< 47);
    if (v > hi) begin
      return hi[ACC_W-1:0];
    end else if (v < lo) begin
      return lo[ACC_W-1:0];
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/bscs_ram.sv -----
`timescale 1ns / 1ps

module bscs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/bscs_mul4.sv -----
`timescale 1ns / 1ps

module bscs_mul4 (
  input  logic           clk,
  input  logic           en,
  input  bscs_pkg::word_t a [4],
  input  bscs_pkg::word_t b [4],
  output bscs_pkg::prod_t p_r [4]
);

  // Four exact 32x32 products, registered; they hold while en is low.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p_r[k] <= a[k] * b[k];
      end
    end
  end

endmodule

// ----- hw/rtl/bsr_symmetric_conj_spmv_top.sv -----
`timescale 1ns / 1ps
// Load: written on acceptance, no result. Matrix element: states E1 to E4, no result.
// Read: states R1 to R4 up to the result register, held in R4 only while out_tready is low.
// One request is worked at a time; the step sequences are set by the single read port
// of each memory and the shared bank of four multipliers.
// Reset clears control and configuration; vector memories hold garbage until loaded.
module bsr_symmetric_conj_spmv_top #(
  parameter int VEC_LEN   = 1024,
  parameter int MAX_BLOCK = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vec_index, x_real, x_imag, y_real, y_imag, blk_row, blk_col,
  // row_in_block, col_in_block, val_real, val_imag, zero pad
  input  logic [231:0] in_tdata,
  // op
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_index, out_real, out_imag, zero pad
  output logic [79:0]  out_tdata,
  // saturated
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int IDX_W = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int AW    = bscs_pkg::ACC_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_E1   = 9'b000000010,
    S_E2   = 9'b000000100,
    S_E3   = 9'b000001000,
    S_E4   = 9'b000010000,
    S_R1   = 9'b000100000,
    S_R2   = 9'b001000000,
    S_R3   = 9'b010000000,
    S_R4   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Input field unpacking.
  logic [9:0]      f_vidx, f_brow, f_bcol;
  logic [2:0]      f_ri, f_ci;
  bscs_pkg::word_t f_xr, f_xi, f_yr, f_yi, f_vr, f_vi;
  assign f_vidx = in_tdata[9:0];
  assign f_xr   = in_tdata[41:10];
  assign f_xi   = in_tdata[73:42];
  assign f_yr   = in_tdata[105:74];
  assign f_yi   = in_tdata[137:106];
  assign f_brow = in_tdata[147:138];
  assign f_bcol = in_tdata[157:148];
  assign f_ri   = in_tdata[160:158];
  assign f_ci   = in_tdata[163:161];
  assign f_vr   = in_tdata[195:164];
  assign f_vi   = in_tdata[227:196];

  // Configuration registers.
  bscs_pkg::word_t alpha_re_r, alpha_im_r, beta_re_r, beta_im_r;
  logic [3:0]      blk_size_r;
  logic [10:0]     num_brow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_re_r <= 32'sd65536;
      alpha_im_r <= '0;
      beta_re_r  <= '0;
      beta_im_r  <= '0;
      blk_size_r <= 4'd1;
      num_brow_r <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        bscs_pkg::CFG_ALPHA_RE: alpha_re_r <= cfg_wdata;
        bscs_pkg::CFG_ALPHA_IM: alpha_im_r <= cfg_wdata;
        bscs_pkg::CFG_BETA_RE:  beta_re_r  <= cfg_wdata;
        bscs_pkg::CFG_BETA_IM:  beta_im_r  <= cfg_wdata;
        bscs_pkg::CFG_BLK_SIZE: blk_size_r <= cfg_wdata[3:0];
        bscs_pkg::CFG_NUM_BROW: num_brow_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Global row and column of a matrix element, and its range checks.
  logic [bscs_pkg::POS_W-1:0] bs_eff, nb_eff, dim, pos_r, pos_c, vidx_ext, vlen;
  logic                       elem_ok, idx_ok;
  always_comb begin
    if (blk_size_r == 4'd0) begin
      bs_eff = bscs_pkg::POS_W'(1);
    end else if (bscs_pkg::POS_W'(blk_size_r) > bscs_pkg::POS_W'(MAX_BLOCK)) begin
      bs_eff = bscs_pkg::POS_W'(MAX_BLOCK);
    end else begin
      bs_eff = bscs_pkg::POS_W'(blk_size_r);
    end
    nb_eff   = (num_brow_r == 11'd0) ? bscs_pkg::POS_W'(1) : bscs_pkg::POS_W'(num_brow_r);
    dim      = nb_eff * bs_eff;
    pos_r    = bscs_pkg::POS_W'(f_brow) * bs_eff + bscs_pkg::POS_W'(f_ri);
    pos_c    = bscs_pkg::POS_W'(f_bcol) * bs_eff + bscs_pkg::POS_W'(f_ci);
    vlen     = bscs_pkg::POS_W'(VEC_LEN);
    vidx_ext = bscs_pkg::POS_W'(f_vidx);
    idx_ok   = vidx_ext < vlen;
    elem_ok  = (bscs_pkg::POS_W'(f_ri) < bs_eff) && (bscs_pkg::POS_W'(f_ci) < bs_eff)
            && (pos_r < dim) && (pos_c < dim) && (pos_r < vlen) && (pos_c < vlen)
            && (pos_r < pos_c);
  end

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Request registers.
  logic [IDX_W-1:0] row_r, col_r;
  logic [9:0]       vidx_r;
  bscs_pkg::word_t  vr_r, vi_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r  <= pos_r[IDX_W-1:0];
      col_r  <= pos_c[IDX_W-1:0];
      vidx_r <= f_vidx;
      vr_r   <= f_vr;
      vi_r   <= f_vi;
    end
  end

  // Memories.
  logic                 x_we, y_we, acc_we, x_re, y_re, acc_re;
  logic [IDX_W-1:0]     x_raddr, acc_raddr, acc_waddr, ld_addr;
  logic [63:0]          x_rdata, y_rdata;
  logic [2*AW-1:0]      acc_rdata, acc_wdata;

  assign ld_addr = vidx_ext[IDX_W-1:0];
  assign x_we    = in_acc && (in_tuser == bscs_pkg::OP_LOAD) && idx_ok;
  assign y_we    = x_we;

  bscs_ram #(.WIDTH(64), .DEPTH(VEC_LEN), .AW(IDX_W)) u_xram (
    .clk(clk), .we(x_we), .waddr(ld_addr), .wdata({f_xi, f_xr}),
    .re(x_re), .raddr(x_raddr), .rdata_r(x_rdata)
  );

  bscs_ram #(.WIDTH(64), .DEPTH(VEC_LEN), .AW(IDX_W)) u_yram (
    .clk(clk), .we(y_we), .waddr(ld_addr), .wdata({f_yi, f_yr}),
    .re(y_re), .raddr(ld_addr), .rdata_r(y_rdata)
  );

  bscs_ram #(.WIDTH(2*AW), .DEPTH(VEC_LEN), .AW(IDX_W)) u_accram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata_r(acc_rdata)
  );

  bscs_pkg::word_t xd_re, xd_im, yd_re, yd_im;
  logic signed [AW-1:0] accd_re, accd_im;
  assign xd_re   = x_rdata[31:0];
  assign xd_im   = x_rdata[63:32];
  assign yd_re   = y_rdata[31:0];
  assign yd_im   = y_rdata[63:32];
  assign accd_re = acc_rdata[AW-1:0];
  assign accd_im = acc_rdata[2*AW-1:AW];

  // Shared multiplier bank.
  bscs_pkg::word_t mul_a [4];
  bscs_pkg::word_t mul_b [4];
  bscs_pkg::prod_t p [4];
  logic            mul_en;

  bscs_mul4 u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p_r(p));

  // Intermediate registers.
  logic signed [48:0] t_re_r, t_im_r, t_re_nxt, t_im_nxt;
  bscs_pkg::word_t    s_re_r, s_im_r, y_re_r, y_im_r;
  logic               sat_r;
  logic signed [49:0] rr_r, rr_nxt, ri_sum;
  bscs_pkg::sat32_t   s_re_c, s_im_c, o_re_c, o_im_c;

  // Element sums: conj(v)*x, floored to Q16.16.
  assign t_re_nxt = 49'((65'(p[0]) + 65'(p[1])) >>> 16);
  assign t_im_nxt = 49'((65'(p[2]) - 65'(p[3])) >>> 16);
  // Read sums: beta*y + alpha*s, floored to Q16.16.
  assign rr_nxt = 50'((66'(p[0]) - 66'(p[1]) + 66'(p[2]) - 66'(p[3])) >>> 16);
  assign ri_sum = 50'((66'(p[0]) + 66'(p[1]) + 66'(p[2]) + 66'(p[3])) >>> 16);

  assign s_re_c = bscs_pkg::sat32(50'(xd_re) + 50'(accd_re));
  assign s_im_c = bscs_pkg::sat32(50'(xd_im) + 50'(accd_im));
  assign o_re_c = bscs_pkg::sat32(rr_r);
  assign o_im_c = bscs_pkg::sat32(ri_sum);

  // Output register.
  logic        out_valid_r, out_sat_r;
  logic [9:0]  out_idx_r;
  bscs_pkg::word_t out_re_r, out_im_r;
  logic        out_free, out_load;

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == S_R4) && out_free;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    x_re      = 1'b0;
    y_re      = 1'b0;
    acc_re    = 1'b0;
    x_raddr   = ld_addr;
    acc_raddr = ld_addr;
    acc_we    = 1'b0;
    acc_waddr = ld_addr;
    acc_wdata = '0;
    mul_en    = 1'b0;
    for (int k = 0; k < 4; k++) begin
      mul_a[k] = '0;
      mul_b[k] = '0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            bscs_pkg::OP_LOAD: begin
              acc_we = idx_ok;
            end
            bscs_pkg::OP_ELEM: begin
              if (elem_ok) begin
                x_re      = 1'b1;
                x_raddr   = pos_c[IDX_W-1:0];
                state_nxt = S_E1;
              end
            end
            bscs_pkg::OP_READ: begin
              if (idx_ok) begin
                x_re      = 1'b1;
                y_re      = 1'b1;
                acc_re    = 1'b1;
                state_nxt = S_R1;
              end
            end
            default: ;
          endcase
        end
      end
      S_E1: begin
        mul_en = 1'b1;
        mul_a  = '{vr_r, vi_r, vr_r, vi_r};
        mul_b  = '{xd_re, xd_im, xd_im, xd_re};
        x_re      = 1'b1;
        x_raddr   = row_r;
        state_nxt = S_E2;
      end
      S_E2: begin
        mul_en = 1'b1;
        mul_a  = '{vr_r, vi_r, vr_r, vi_r};
        mul_b  = '{xd_re, xd_im, xd_im, xd_re};
        acc_re    = 1'b1;
        acc_raddr = row_r;
        state_nxt = S_E3;
      end
      S_E3: begin
        acc_we    = 1'b1;
        acc_waddr = row_r;
        acc_wdata = {bscs_pkg::sat48(50'(accd_im) + 50'(t_im_r)),
                     bscs_pkg::sat48(50'(accd_re) + 50'(t_re_r))};
        acc_re    = 1'b1;
        acc_raddr = col_r;
        state_nxt = S_E4;
      end
      S_E4: begin
        acc_we    = 1'b1;
        acc_waddr = col_r;
        acc_wdata = {bscs_pkg::sat48(50'(accd_im) + 50'(t_im_r)),
                     bscs_pkg::sat48(50'(accd_re) + 50'(t_re_r))};
        state_nxt = S_IDLE;
      end
      S_R1: begin
        state_nxt = S_R2;
      end
      S_R2: begin
        mul_en = 1'b1;
        mul_a  = '{beta_re_r, beta_im_r, alpha_re_r, alpha_im_r};
        mul_b  = '{y_re_r, y_im_r, s_re_r, s_im_r};
        state_nxt = S_R3;
      end
      S_R3: begin
        mul_en = 1'b1;
        mul_a  = '{beta_re_r, beta_im_r, alpha_re_r, alpha_im_r};
        mul_b  = '{y_im_r, y_re_r, s_im_r, s_re_r};
        state_nxt = S_R4;
      end
      S_R4: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_E2 || state_r == S_E3) begin
      t_re_r <= t_re_nxt;
      t_im_r <= t_im_nxt;
    end
    if (state_r == S_R1) begin
      s_re_r <= s_re_c.val;
      s_im_r <= s_im_c.val;
      y_re_r <= yd_re;
      y_im_r <= yd_im;
      sat_r  <= s_re_c.sat | s_im_c.sat;
    end
    if (state_r == S_R3) begin
      rr_r <= rr_nxt;
    end
    if (out_load) begin
      out_idx_r <= vidx_r;
      out_re_r  <= o_re_c.val;
      out_im_r  <= o_im_c.val;
      out_sat_r <= sat_r | o_re_c.sat | o_im_c.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_im_r, out_re_r, out_idx_r};
  assign out_tuser  = out_sat_r;

  // A result appears only from the last read step.
  a_out_from_r4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_R4))
    else $error("result appeared outside the read sequence");

  // The two accumulator updates of one element hit different entries.
  a_acc_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E4) |-> (acc_waddr != $past(acc_waddr)))
    else $error("element updated the same accumulator twice");

  // Element sequence starts only from idle.
  a_e1_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E1) |-> $past(state_r == S_IDLE))
    else $error("element sequence entered without a request");

endmodule
